>>> src/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, pre, post)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

>>> src/cpr_pkg.sv
// ---------------------------------------------------------------------------
// cpr_pkg
// Constants and codes for the clock page replacement block.
// ---------------------------------------------------------------------------
package cpr_pkg;
   localparam int PROCS     = 8;
   localparam int FRAMES    = 16;
   localparam int PAGE_BITS = 20;
   localparam int PID_W     = 3;
   localparam int FRM_W     = 4;
   localparam int SLOT_W    = PID_W + FRM_W;
   localparam int CNT_W     = 32;

   localparam logic CSR_FRAMES = 1'b0;
   localparam logic CSR_PROCS  = 1'b1;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SEARCH = 3'd1;
   localparam logic [2:0] ST_SWEEP  = 3'd2;
   localparam logic [2:0] ST_DONE   = 3'd3;
endpackage

>>> src/clock_page_replacement.sv
// ---------------------------------------------------------------------------
// clock_page_replacement
// Second-chance page replacement with one frame set and hand per process.
// ---------------------------------------------------------------------------
// Bad process: straight to the result. Hit: search from frame 0 to the match.
// Miss: search all n frames in use, then sweep from the hand, clearing s <= n
//   set reference bits up to a clear one. One item at a time; busy covers the
//   result cycle, so the next item goes in the cycle after it.
// Reset: valid/ref bits, hands and counters cleared at once (flip-flops);
//   page tag memory needs no clearing, registers return to 16 and 8.
`include "assert_macros.svh"

module clock_page_replacement (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_process_id,
   input  logic [19:0] req_page_number,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [4:0]  csr_data,
   output logic        rsp_valid,
   output logic        rsp_hit,
   output logic [3:0]  rsp_frame_index,
   output logic        rsp_evicted_valid,
   output logic [19:0] rsp_evicted_page,
   output logic [31:0] rsp_fault_count,
   output logic [31:0] rsp_reference_count,
   output logic        rsp_bad_process
);
   localparam int SLOTS = cpr_pkg::PROCS * cpr_pkg::FRAMES;

   // page tag memory, one synchronous read port
   logic [cpr_pkg::PAGE_BITS-1:0] page_mem [SLOTS];
   logic [cpr_pkg::PAGE_BITS-1:0] page_rd_ff;
   logic [cpr_pkg::SLOT_W-1:0]    rd_addr;
   logic                          mem_we;

   logic [SLOTS-1:0] valid_ff, refd_ff;
   logic [cpr_pkg::FRM_W-1:0] hand_ff [cpr_pkg::PROCS];
   logic [cpr_pkg::CNT_W-1:0] faults_ff [cpr_pkg::PROCS];
   logic [cpr_pkg::CNT_W-1:0] refs_ff [cpr_pkg::PROCS];

   logic [4:0] fpp_ff;
   logic [3:0] act_ff;
   logic [2:0] state_ff;
   logic [cpr_pkg::PID_W-1:0] pid_ff;
   logic [cpr_pkg::PAGE_BITS-1:0] page_ff;
   logic [cpr_pkg::FRM_W-1:0] idx_ff;   // frame being read / examined
   logic [4:0] step_ff;
   logic       rd_pend_ff;              // page_rd_ff holds entry idx_ff
   logic [4:0] nf;
   logic [cpr_pkg::FRM_W-1:0] last_frame, next_idx;
   logic [cpr_pkg::SLOT_W-1:0] slot;

   // frames in use: 0 acts as 1, clamp at FRAMES
   always_comb begin
      if (fpp_ff == 5'd0) begin
         nf = 5'd1;
      end else if (fpp_ff > 5'd16) begin
         nf = 5'd16;
      end else begin
         nf = fpp_ff;
      end
      last_frame = cpr_pkg::FRM_W'(nf - 5'd1);
      next_idx   = (idx_ff == last_frame) ? '0 : idx_ff + 1'b1;
      slot       = {pid_ff, idx_ff};
   end

   assign busy = (state_ff != cpr_pkg::ST_IDLE);

   // result strobe: the done state is entered only with a result loaded
   assign rsp_valid = (state_ff == cpr_pkg::ST_DONE);

   // memory read/write; once a read is in hand, fetch the next frame ahead
   always_comb begin
      rd_addr = rd_pend_ff ? {pid_ff, next_idx} : slot;
      mem_we  = (state_ff == cpr_pkg::ST_SWEEP) && rd_pend_ff && !refd_ff[slot];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         page_mem[slot] <= page_ff;
      end
      page_rd_ff <= page_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= cpr_pkg::ST_IDLE;
         fpp_ff    <= 5'd16;
         act_ff    <= 4'd8;
         valid_ff  <= '0;
         refd_ff   <= '0;
         rd_pend_ff <= 1'b0;
         for (int p = 0; p < cpr_pkg::PROCS; p++) begin
            hand_ff[p]   <= '0;
            faults_ff[p] <= '0;
            refs_ff[p]   <= '0;
         end
      end else begin
         if (csr_write) begin
            if (csr_index == cpr_pkg::CSR_FRAMES) begin
               fpp_ff <= csr_data;
            end else begin
               act_ff <= csr_data[3:0];
            end
         end
         case (state_ff)
            cpr_pkg::ST_IDLE: begin
               if (start) begin
                  pid_ff  <= req_process_id;
                  page_ff <= req_page_number;
                  idx_ff  <= '0;
                  rd_pend_ff <= 1'b0;
                  if ({1'b0, req_process_id} >= act_ff) begin
                     rsp_bad_process <= 1'b1;
                     rsp_hit <= 1'b0;
                     rsp_frame_index <= '0;
                     rsp_evicted_valid <= 1'b0;
                     rsp_evicted_page <= '0;
                     rsp_fault_count <= '0;
                     rsp_reference_count <= '0;
                     state_ff <= cpr_pkg::ST_DONE;
                  end else begin
                     state_ff <= cpr_pkg::ST_SEARCH;
                  end
               end
            end
            cpr_pkg::ST_SEARCH: begin
               // first cycle issues the read of idx_ff; later cycles compare
               if (!rd_pend_ff) begin
                  rd_pend_ff <= 1'b1;
               end else if (valid_ff[slot] && page_rd_ff == page_ff) begin
                  refd_ff[slot] <= 1'b1;
                  refs_ff[pid_ff] <= (&refs_ff[pid_ff]) ? refs_ff[pid_ff]
                                                        : refs_ff[pid_ff] + 1'b1;
                  rsp_bad_process <= 1'b0;
                  rsp_hit <= 1'b1;
                  rsp_frame_index <= idx_ff;
                  rsp_evicted_valid <= 1'b0;
                  rsp_evicted_page <= '0;
                  rsp_fault_count <= faults_ff[pid_ff];
                  rsp_reference_count <= (&refs_ff[pid_ff]) ? refs_ff[pid_ff]
                                                            : refs_ff[pid_ff] + 1'b1;
                  state_ff <= cpr_pkg::ST_DONE;
               end else if (idx_ff == last_frame) begin
                  faults_ff[pid_ff] <= (&faults_ff[pid_ff]) ? faults_ff[pid_ff]
                                                            : faults_ff[pid_ff] + 1'b1;
                  idx_ff <= (hand_ff[pid_ff] > last_frame) ? '0 : hand_ff[pid_ff];
                  rd_pend_ff <= 1'b0;
                  step_ff <= '0;
                  state_ff <= cpr_pkg::ST_SWEEP;
               end else begin
                  idx_ff <= next_idx;
               end
            end
            cpr_pkg::ST_SWEEP: begin
               if (!rd_pend_ff) begin
                  rd_pend_ff <= 1'b1;
               end else if (!refd_ff[slot]) begin
                  valid_ff[slot] <= 1'b1;
                  refd_ff[slot]  <= 1'b1;
                  hand_ff[pid_ff] <= next_idx;
                  refs_ff[pid_ff] <= (&refs_ff[pid_ff]) ? refs_ff[pid_ff]
                                                        : refs_ff[pid_ff] + 1'b1;
                  rsp_bad_process <= 1'b0;
                  rsp_hit <= 1'b0;
                  rsp_frame_index <= idx_ff;
                  rsp_evicted_valid <= valid_ff[slot];
                  rsp_evicted_page <= valid_ff[slot] ? page_rd_ff : '0;
                  rsp_fault_count <= faults_ff[pid_ff];
                  rsp_reference_count <= (&refs_ff[pid_ff]) ? refs_ff[pid_ff]
                                                            : refs_ff[pid_ff] + 1'b1;
                  state_ff <= cpr_pkg::ST_DONE;
               end else begin
                  // second chance: clear and move on, one frame a cycle
                  refd_ff[slot] <= 1'b0;
                  idx_ff <= next_idx;
                  step_ff <= step_ff + 1'b1;
               end
            end
            cpr_pkg::ST_DONE: begin
               state_ff <= cpr_pkg::ST_IDLE;
            end
            default: begin
               state_ff <= cpr_pkg::ST_IDLE;
            end
         endcase
      end
   end

   `ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `ASSERT_IMPLIES(a_rsp_in_done, clock, reset, rsp_valid, state_ff == cpr_pkg::ST_DONE)
   `ASSERT_IMPLIES(a_sweep_bound, clock, reset, state_ff == cpr_pkg::ST_SWEEP, step_ff <= 5'd17)
   `ASSERT_NEXT(a_one_strobe, clock, reset, rsp_valid, !rsp_valid)
endmodule
